// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules of the decimator
// the checks drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CHK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHK_ASSERT(lbl, clk, rst, prop)
`define CHK_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/mmbd_pkg.sv =====
// constants shared by the min/max bucket decimator
// csr widths, register indexes and reset values; no dependencies
`default_nettype none
package mmbd_pkg;
   localparam int TOTAL_BITS     = 25;
   localparam int BUCKET_BITS    = 24;
   localparam int CSR_DATA_BITS  = TOTAL_BITS;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOTAL_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUCKET_COUNT = 1'b1;

   localparam logic [TOTAL_BITS-1:0]  TOTAL_RESET  = 25'd2;
   localparam logic [BUCKET_BITS-1:0] BUCKET_RESET = 24'd1;
endpackage
`default_nettype wire

// ===== hw/rtl/mmbd_tracker.sv =====
// bucket tracker: csr registers, frame position and running min/max
// uses mmbd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module mmbd_tracker #(
   parameter int INDEX_BITS = 24,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write,
   input  wire logic [mmbd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [mmbd_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [VALUE_BITS-1:0]         req_sample_value,
   input  wire logic                                 rec_ready,
   output logic                                      rec_valid,
   output logic [2*VALUE_BITS+2*INDEX_BITS:0]        rec_data
);
   import mmbd_pkg::*;

   // (i+1)*B and (k+1)*N both fit here without wrapping
   localparam int POS_BITS = INDEX_BITS + 26;

   logic [TOTAL_BITS-1:0]         total_ff, total_in;
   logic [BUCKET_BITS-1:0]        bucket_ff, bucket_in;
   logic [INDEX_BITS-1:0]         counter_ff, counter_in;
   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic [POS_BITS-1:0]           end_ff, end_in;
   logic                          open_ff, open_in;
   logic signed [VALUE_BITS-1:0]  min_value_ff, min_value_in;
   logic signed [VALUE_BITS-1:0]  max_value_ff, max_value_in;
   logic [INDEX_BITS-1:0]         min_index_ff, min_index_in;
   logic [INDEX_BITS-1:0]         max_index_ff, max_index_in;

   logic                  accept;
   logic [POS_BITS-1:0]   n_ext;
   logic [POS_BITS-1:0]   b_ext;
   logic [POS_BITS-1:0]   next_pos;
   logic [POS_BITS-1:0]   i_plus_one;
   logic                  frame_last;
   logic                  closing;

   assign req_ready = rec_ready;
   assign accept    = req_valid & req_ready;

   always_comb begin
      n_ext      = {{(POS_BITS-TOTAL_BITS){1'b0}}, total_ff};
      b_ext      = {{(POS_BITS-BUCKET_BITS){1'b0}}, bucket_ff};
      next_pos   = pos_ff + b_ext;
      i_plus_one = {{(POS_BITS-INDEX_BITS){1'b0}}, counter_ff} + POS_BITS'(1);
      frame_last = (i_plus_one >= n_ext) || (&counter_ff);
      closing    = frame_last || ((next_pos + b_ext) > end_ff);

      // running extremes including the current word, first index wins ties
      if (!open_ff) begin
         min_value_in = req_sample_value;
         min_index_in = counter_ff;
         max_value_in = req_sample_value;
         max_index_in = counter_ff;
      end else begin
         min_value_in = min_value_ff;
         min_index_in = min_index_ff;
         max_value_in = max_value_ff;
         max_index_in = max_index_ff;
         if (req_sample_value < min_value_ff) begin
            min_value_in = req_sample_value;
            min_index_in = counter_ff;
         end
         if (req_sample_value > max_value_ff) begin
            max_value_in = req_sample_value;
            max_index_in = counter_ff;
         end
      end

      total_in   = total_ff;
      bucket_in  = bucket_ff;
      counter_in = counter_ff;
      pos_in     = pos_ff;
      end_in     = end_ff;
      open_in    = open_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_TOTAL_COUNT:  total_in  = csr_data;
            CSR_BUCKET_COUNT: bucket_in = csr_data[BUCKET_BITS-1:0];
            default:          total_in  = total_ff;
         endcase
         // any write restarts the frame
         counter_in = '0;
         pos_in     = '0;
         end_in     = {{(POS_BITS-TOTAL_BITS){1'b0}}, total_in};
         open_in    = 1'b0;
      end else if (accept) begin
         open_in = ~closing;
         if (closing) begin
            end_in = end_ff + n_ext;
         end
         if (frame_last) begin
            counter_in = '0;
            pos_in     = '0;
            end_in     = n_ext;
         end else begin
            counter_in = counter_ff + INDEX_BITS'(1);
            pos_in     = next_pos;
         end
      end
   end

   assign rec_valid = accept & closing;
   assign rec_data  = {frame_last, max_index_in, max_value_in, min_index_in, min_value_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= TOTAL_RESET;
         bucket_ff  <= BUCKET_RESET;
         counter_ff <= '0;
         pos_ff     <= '0;
         end_ff     <= {{(POS_BITS-TOTAL_BITS){1'b0}}, TOTAL_RESET};
         open_ff    <= 1'b0;
      end else begin
         total_ff   <= total_in;
         bucket_ff  <= bucket_in;
         counter_ff <= counter_in;
         pos_ff     <= pos_in;
         end_ff     <= end_in;
         open_ff    <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         min_value_ff <= min_value_in;
         min_index_ff <= min_index_in;
         max_value_ff <= max_value_in;
         max_index_ff <= max_index_in;
      end
   end

   `CHK_ASSERT_NEXT(a_frame_restart, clock, reset, accept && frame_last && !csr_write, counter_ff == '0 && !open_ff)
   `CHK_ASSERT_NEXT(a_close_empties, clock, reset, rec_valid && !csr_write, !open_ff)
endmodule
`default_nettype wire

// ===== hw/rtl/mmbd_queue.sv =====
// two-entry queue of closed-bucket records between tracker and emitter
// no package dependency; uses assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module mmbd_queue #(
   parameter int WIDTH = 113
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  not_full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      pop_data
);
   localparam int DEPTH    = 2;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    data_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign not_full  = (count_ff != CNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = data_ff[rd_ptr_ff];
   assign do_push   = push & not_full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CHK_ASSERT(a_no_overflow, clock, reset, !(push && !not_full))
   `CHK_ASSERT(a_count_range, clock, reset, count_ff <= CNT_BITS'(DEPTH))
endmodule
`default_nettype wire

// ===== hw/rtl/mmbd_emitter.sv =====
// result stage: turns a bucket record into one or two point words
// no package dependency; uses assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module mmbd_emitter #(
   parameter int INDEX_BITS = 24,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               rec_valid,
   input  wire logic [2*VALUE_BITS+2*INDEX_BITS:0] rec_data,
   output logic                                    rec_pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [INDEX_BITS-1:0]                   rsp_point_index,
   output logic signed [VALUE_BITS-1:0]            rsp_point_value,
   output logic                                    rsp_last_of_run,
   output logic                                    rsp_frame_end
);
   localparam int MIN_IDX_LO = VALUE_BITS;
   localparam int MAX_VAL_LO = VALUE_BITS + INDEX_BITS;
   localparam int MAX_IDX_LO = 2*VALUE_BITS + INDEX_BITS;
   localparam int FLAST_POS  = 2*VALUE_BITS + 2*INDEX_BITS;

   logic signed [VALUE_BITS-1:0] r_min_value, r_max_value;
   logic [INDEX_BITS-1:0]        r_min_index, r_max_index;
   logic                         r_frame_last;

   logic                         out_valid_ff, out_valid_in;
   logic [INDEX_BITS-1:0]        out_index_ff, out_index_in;
   logic signed [VALUE_BITS-1:0] out_value_ff, out_value_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_fend_ff, out_fend_in;

   logic                         pend_valid_ff, pend_valid_in;
   logic [INDEX_BITS-1:0]        pend_index_ff, pend_index_in;
   logic signed [VALUE_BITS-1:0] pend_value_ff, pend_value_in;
   logic                         pend_fend_ff, pend_fend_in;

   logic                         load;

   assign r_min_value  = rec_data[VALUE_BITS-1:0];
   assign r_min_index  = rec_data[MIN_IDX_LO +: INDEX_BITS];
   assign r_max_value  = rec_data[MAX_VAL_LO +: VALUE_BITS];
   assign r_max_index  = rec_data[MAX_IDX_LO +: INDEX_BITS];
   assign r_frame_last = rec_data[FLAST_POS];

   // output register may be refilled when empty or being taken
   assign load    = ~out_valid_ff | rsp_ready;
   assign rec_pop = load & ~pend_valid_ff & rec_valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_index_in  = out_index_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      out_fend_in   = out_fend_ff;
      pend_valid_in = pend_valid_ff;
      pend_index_in = pend_index_ff;
      pend_value_in = pend_value_ff;
      pend_fend_in  = pend_fend_ff;

      if (load) begin
         priority if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_index_in  = pend_index_ff;
            out_value_in  = pend_value_ff;
            out_last_in   = 1'b1;
            out_fend_in   = pend_fend_ff;
            pend_valid_in = 1'b0;
         end else if (rec_valid) begin
            out_valid_in = 1'b1;
            pend_fend_in = r_frame_last;
            if (r_min_index == r_max_index) begin
               // both extremes on one sample: a single point
               out_index_in = r_min_index;
               out_value_in = r_min_value;
               out_last_in  = 1'b1;
               out_fend_in  = r_frame_last;
            end else begin
               out_last_in   = 1'b0;
               out_fend_in   = 1'b0;
               pend_valid_in = 1'b1;
               if (r_min_index < r_max_index) begin
                  out_index_in  = r_min_index;
                  out_value_in  = r_min_value;
                  pend_index_in = r_max_index;
                  pend_value_in = r_max_value;
               end else begin
                  out_index_in  = r_max_index;
                  out_value_in  = r_max_value;
                  pend_index_in = r_min_index;
                  pend_value_in = r_min_value;
               end
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_index_ff  <= out_index_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      out_fend_ff   <= out_fend_in;
      pend_index_ff <= pend_index_in;
      pend_value_ff <= pend_value_in;
      pend_fend_ff  <= pend_fend_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_point_index = out_index_ff;
   assign rsp_point_value = out_value_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_frame_end   = out_fend_ff;

   `CHK_ASSERT(a_pend_behind_out, clock, reset, pend_valid_ff |-> (out_valid_ff && !out_last_ff))
   `CHK_ASSERT(a_fend_on_last, clock, reset, (out_valid_ff && out_fend_ff) |-> out_last_ff)
endmodule
`default_nettype wire

// ===== hw/rtl/min_max_bucket_decimator.sv =====
// top level of the peak-preserving min/max bucket decimator
// instantiates mmbd_tracker, mmbd_queue and mmbd_emitter; uses mmbd_pkg
//
// Usage: samples of a frame enter one word per cycle on req_ (valid/ready).
// total_count (index 0) and bucket_count (index 1) are written on the csr_
// port while the block is idle; any write restarts the frame. When the last
// sample of a bucket is taken, the bucket's minimum and maximum leave on
// rsp_ in index order, or one point when both sit on the same sample;
// last_of_run marks the final word of a bucket and frame_end the final
// word of the frame.
// Throughput: one sample per cycle while the queue has room, limited by the
// tracker update. A bucket yields up to two words, drained one per cycle while rsp_ready is high.
// Path: a bucket's record is written into the queue as its closing sample is
// taken; its first word is then loaded into the emitter output register.
// Stalls: a two-record queue and the output register absorb rsp_ready low;
// req_ready drops only when both queue slots hold records.
// Reset: frame position cleared, total_count = 2, bucket_count = 1,
// no results pending; no clearing pass.
`default_nettype none
module min_max_bucket_decimator #(
   parameter int INDEX_BITS = 24,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write,
   input  wire logic [mmbd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [mmbd_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [VALUE_BITS-1:0]         req_sample_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [INDEX_BITS-1:0]                     rsp_point_index,
   output logic signed [VALUE_BITS-1:0]              rsp_point_value,
   output logic                                      rsp_last_of_run,
   output logic                                      rsp_frame_end
);
   localparam int REC_BITS = 2*VALUE_BITS + 2*INDEX_BITS + 1;

   logic                rec_push;
   logic [REC_BITS-1:0] rec_push_data;
   logic                rec_not_full;
   logic                rec_pop;
   logic                rec_not_empty;
   logic [REC_BITS-1:0] rec_pop_data;

   mmbd_tracker #(
      .INDEX_BITS (INDEX_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_tracker (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .rec_ready        (rec_not_full),
      .rec_valid        (rec_push),
      .rec_data         (rec_push_data)
   );

   mmbd_queue #(
      .WIDTH (REC_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_push_data),
      .not_full  (rec_not_full),
      .pop       (rec_pop),
      .not_empty (rec_not_empty),
      .pop_data  (rec_pop_data)
   );

   mmbd_emitter #(
      .INDEX_BITS (INDEX_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_emitter (
      .clock           (clock),
      .reset           (reset),
      .rec_valid       (rec_not_empty),
      .rec_data        (rec_pop_data),
      .rec_pop         (rec_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_index (rsp_point_index),
      .rsp_point_value (rsp_point_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end)
   );
endmodule
`default_nettype wire

// ===== bench/min_max_bucket_decimator_tb.sv =====
// self-checking bench for min_max_bucket_decimator: directed table, then random frames
// with random idling on both sides, every point checked against an in-bench predictor
// depends on mmbd_pkg and the min_max_bucket_decimator rtl
`default_nettype none
module min_max_bucket_decimator_tb;
   import mmbd_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 150;
   // longest quiet stretch of a correct run is the long hold; allow many times that
   localparam int QUIET_LIMIT   = 2000;
   localparam int MAX_SHOWN     = 30;

   typedef struct packed {
      logic [23:0] idx;
      logic [31:0] value;
      logic        last;
      logic        fend;
   } point_type;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] reg_sel;
      logic [CSR_DATA_BITS-1:0]  reg_data;
      logic [31:0]               sample;
      bit                        typed;
      point_type                 final_point;
   } stim_row_type;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      csr_write        = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data         = '0;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic signed [31:0]        req_sample_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic [23:0]               rsp_point_index;
   logic signed [31:0]        rsp_point_value;
   logic                      rsp_last_of_run;
   logic                      rsp_frame_end;

   // predictor state
   point_type          expected_points[$];
   stim_row_type       directed_rows[$];
   logic [63:0]        frame_len;
   logic [63:0]        buckets_per_frame;
   logic [63:0]        scaled_pos;
   logic [63:0]        scaled_end;
   logic [23:0]        next_index;
   logic [23:0]        low_index;
   logic [23:0]        high_index;
   logic signed [31:0] low_value;
   logic signed [31:0] high_value;
   bit                 bucket_live;

   int mismatches   = 0;
   int samples_sent = 0;
   int points_seen  = 0;
   int csr_writes   = 0;
   int quiet_cycles = 0;
   bit sender_calm   = 1'b0;
   bit receiver_calm = 1'b0;
   bit hold_due      = 1'b0;

   min_max_bucket_decimator i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_index  (rsp_point_index),
      .rsp_point_value  (rsp_point_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_frame_end    (rsp_frame_end)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic point_type make_point(input logic [23:0] i, input logic [31:0] v,
                                            input logic last, input logic fend);
      point_type pt;
      pt.idx   = i;
      pt.value = v;
      pt.last  = last;
      pt.fend  = fend;
      return pt;
   endfunction

   task automatic restart_frame_model();
      next_index  = '0;
      scaled_pos  = '0;
      scaled_end  = frame_len;
      low_value   = '0;
      low_index   = '0;
      high_value  = '0;
      high_index  = '0;
      bucket_live = 1'b0;
   endtask

   // track one sample and queue the points its bucket close produces
   task automatic predict_sample(input logic signed [31:0] v, output int made);
      logic [63:0] pos_next;
      bit          frame_done;
      bit          closes;
      made = 0;
      if (!bucket_live) begin
         low_value   = v;
         low_index   = next_index;
         high_value  = v;
         high_index  = next_index;
         bucket_live = 1'b1;
      end else begin
         if (v < low_value) begin
            low_value = v;
            low_index = next_index;
         end
         if (v > high_value) begin
            high_value = v;
            high_index = next_index;
         end
      end
      pos_next   = scaled_pos + buckets_per_frame;
      // counter at its top value also ends the frame so indices never wrap
      frame_done = ({40'd0, next_index} + 64'd1 >= frame_len) || (next_index == '1);
      closes     = frame_done || (pos_next + buckets_per_frame > scaled_end);
      if (closes) begin
         if (low_index == high_index) begin
            expected_points.push_back(make_point(low_index, low_value, 1'b1, frame_done));
            made = 1;
         end else if (low_index < high_index) begin
            expected_points.push_back(make_point(low_index, low_value, 1'b0, 1'b0));
            expected_points.push_back(make_point(high_index, high_value, 1'b1, frame_done));
            made = 2;
         end else begin
            expected_points.push_back(make_point(high_index, high_value, 1'b0, 1'b0));
            expected_points.push_back(make_point(low_index, low_value, 1'b1, frame_done));
            made = 2;
         end
         bucket_live = 1'b0;
         scaled_end  = scaled_end + frame_len;
      end
      if (frame_done) begin
         restart_frame_model();
      end else begin
         next_index = next_index + 24'd1;
         scaled_pos = pos_next;
      end
   endtask

   // drop valid, wait out every pending point, then let the pipeline empty
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] sel,
                            input logic [CSR_DATA_BITS-1:0] data);
      settle_idle();
      csr_write <= 1'b1;
      csr_index <= sel;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (sel == CSR_TOTAL_COUNT) begin
         frame_len = 64'(data);
      end else if (sel == CSR_BUCKET_COUNT) begin
         buckets_per_frame = 64'(data[BUCKET_BITS-1:0]);
      end
      restart_frame_model();
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [31:0] v, output int made);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_sample(v, made);
      samples_sent++;
   endtask

   function automatic logic [31:0] pick_sample(input logic [31:0] base);
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return $urandom_range(0, 4) - 2;   // small values, plenty of ties
         3: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return base + $urandom_range(0, 15);
      endcase
   endfunction

   task automatic add_write(input logic [CSR_INDEX_BITS-1:0] sel,
                            input logic [CSR_DATA_BITS-1:0] data);
      stim_row_type r;
      r.kind        = ROW_WRITE;
      r.reg_sel     = sel;
      r.reg_data    = data;
      r.sample      = '0;
      r.typed       = 1'b0;
      r.final_point = '0;
      directed_rows.push_back(r);
   endtask

   task automatic add_sample(input logic [31:0] v, input bit typed, input point_type pt);
      stim_row_type r;
      r.kind        = ROW_SAMPLE;
      r.reg_sel     = '0;
      r.reg_data    = '0;
      r.sample      = v;
      r.typed       = typed;
      r.final_point = pt;
      directed_rows.push_back(r);
   endtask

   // receiver: random stall per word, one long hold when asked
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_due) begin
            gap      = LONG_HOLD;
            hold_due = 1'b0;
         end else begin
            gap = receiver_calm ? 0 : $urandom_range(0, 18);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // output checker and watchdog
   always @(posedge clock) begin
      point_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("point at index %0d with none expected",
                                         rsp_point_index));
            end else begin
               want = expected_points.pop_front();
               if (rsp_point_index !== want.idx)
                  report_mismatch($sformatf("point_index %0d, want %0d",
                                            rsp_point_index, want.idx));
               if (rsp_point_value !== want.value)
                  report_mismatch($sformatf("point_value %h, want %h at index %0d",
                                            rsp_point_value, want.value, want.idx));
               if (rsp_last_of_run !== want.last)
                  report_mismatch($sformatf("last_of_run %b, want %b at index %0d",
                                            rsp_last_of_run, want.last, want.idx));
               if (rsp_frame_end !== want.fend)
                  report_mismatch($sformatf("frame_end %b, want %b at index %0d",
                                            rsp_frame_end, want.fend, want.idx));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no word moved for %0d cycles, %0d points outstanding",
                     QUIET_LIMIT, expected_points.size());
            $display("min_max_bucket_decimator verification failed");
            $finish;
         end
      end
   end

   initial begin
      int           made;
      int           phase;
      int           phase_len;
      int           directed_count;
      logic [24:0]  total_pick;
      logic [23:0]  bucket_pick;
      logic         spare_bit;
      logic [31:0]  base;
      stim_row_type row;

      frame_len         = 64'(TOTAL_RESET);
      buckets_per_frame = 64'(BUCKET_RESET);
      restart_frame_model();

      // reset values: two samples make one frame with one bucket
      add_sample(32'h7FFF_FFFF, 1'b0, '0);
      add_sample(32'h8000_0000, 1'b1, make_point(24'd1, 32'h8000_0000, 1'b1, 1'b1));
      // frames of one sample, and of zero which acts the same
      add_write(CSR_TOTAL_COUNT, 25'd1);
      add_sample(32'd5, 1'b1, make_point(24'd0, 32'd5, 1'b1, 1'b1));
      add_write(CSR_TOTAL_COUNT, 25'd0);
      add_sample(32'hFFFF_FFFF, 1'b1, make_point(24'd0, 32'hFFFF_FFFF, 1'b1, 1'b1));
      // zero buckets: only the frame end closes, equal values keep index 0
      add_write(CSR_TOTAL_COUNT, 25'd4);
      add_write(CSR_BUCKET_COUNT, 25'd0);
      repeat (3) add_sample(32'd3, 1'b0, '0);
      add_sample(32'd3, 1'b1, make_point(24'd0, 32'd3, 1'b1, 1'b1));
      // tie on the max keeps the first index, max goes out before min
      add_write(CSR_TOTAL_COUNT, 25'd3);
      add_write(CSR_BUCKET_COUNT, 25'd1);
      add_sample(32'd7, 1'b0, '0);
      add_sample(32'd7, 1'b0, '0);
      add_sample(32'hFFFF_FFFD, 1'b1, make_point(24'd2, 32'hFFFF_FFFD, 1'b1, 1'b1));
      // widest registers, bit 24 of the bucket write is dropped
      add_write(CSR_TOTAL_COUNT, 25'h1FF_FFFF);
      add_write(CSR_BUCKET_COUNT, 25'h1FF_FFFF);
      add_sample(32'd10, 1'b0, '0);
      add_sample(32'hFFFF_FFF6, 1'b0, '0);
      add_sample(32'hFFFF_FFF6, 1'b0, '0);
      add_sample(32'd10, 1'b0, '0);
      // more buckets than half the frame: buckets close early
      add_write(CSR_TOTAL_COUNT, 25'd4);
      add_write(CSR_BUCKET_COUNT, 25'd3);
      add_sample(32'h8000_0000, 1'b0, '0);
      add_sample(32'h7FFF_FFFF, 1'b0, '0);
      add_sample(32'd1, 1'b0, '0);
      add_sample(32'd2, 1'b1, make_point(24'd3, 32'd2, 1'b1, 1'b1));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < directed_rows.size(); k++) begin
         row = directed_rows[k];
         if (row.kind == ROW_WRITE) begin
            write_csr(row.reg_sel, row.reg_data);
         end else begin
            send_sample(row.sample, made);
            if (row.typed && (made == 0 || expected_points[$] != row.final_point))
               report_mismatch($sformatf("directed row %0d: predictor disagrees with table", k));
         end
      end
      directed_count = samples_sent;

      phase = 0;
      while (samples_sent - directed_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               total_pick  = 25'($urandom_range(2, 48));
               bucket_pick = 24'($urandom_range(1, total_pick / 2));
            end
            6: begin
               // unchecked ratio, zero buckets included
               total_pick  = 25'($urandom_range(0, 12));
               bucket_pick = 24'($urandom_range(0, 20));
            end
            7: begin
               total_pick  = '1;
               bucket_pick = '1;
            end
            8: begin
               total_pick  = 25'($urandom_range(32'h100_0000, 32'h1FF_FFFF));
               bucket_pick = total_pick[24:1];
            end
            default: begin
               total_pick  = 25'($urandom_range(0, 3));
               bucket_pick = 24'($urandom_range(0, 3));
            end
         endcase
         // small buckets so the long output hold backs up into the input
         if (phase == 1) begin
            total_pick  = 25'd32;
            bucket_pick = 24'd16;
         end
         spare_bit = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_TOTAL_COUNT, total_pick);
            write_csr(CSR_BUCKET_COUNT, {spare_bit, bucket_pick});
         end else begin
            write_csr(CSR_BUCKET_COUNT, {spare_bit, bucket_pick});
            write_csr(CSR_TOTAL_COUNT, total_pick);
         end
         sender_calm   = (phase == 1) || ($urandom_range(0, 4) == 0);
         receiver_calm = (phase != 1) && ($urandom_range(0, 4) == 0);
         if (phase == 1 || $urandom_range(0, 19) == 0) hold_due = 1'b1;
         base      = $urandom;
         phase_len = (phase == 1) ? 60 : $urandom_range(8, 90);
         repeat (phase_len) send_sample(pick_sample(base), made);
         phase++;
      end

      settle_idle();
      $display("%0d samples over %0d random settings and the directed table, %0d register writes",
               samples_sent, phase, csr_writes);
      $display("%0d points compared, %0d mismatches", points_seen, mismatches);
      if (mismatches == 0) begin
         $display("min_max_bucket_decimator verification clean");
      end else begin
         $display("min_max_bucket_decimator verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
